// ===== src/trace_event_subscription_matcher_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the trace event subscription matcher
// Shared assertion wrappers; they expect clk and arst_n in scope.
// ----------------------------------------------------------------------------
`ifndef TRACE_EVENT_SUBSCRIPTION_MATCHER_DEFINES_SVH
`define TRACE_EVENT_SUBSCRIPTION_MATCHER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define TESM_ASSERT(lbl, prop) lbl: assert property (@(posedge clk) disable iff (!arst_n) \
	prop) else $error("tesm: assertion failed");
`define TESM_ASSERT_IMPL(lbl, cond, prop) lbl: assert property (@(posedge clk) \
	disable iff (!arst_n) (cond) |-> (prop)) else $error("tesm: implication failed");
`define TESM_ASSERT_NEXT(lbl, cond, prop) lbl: assert property (@(posedge clk) \
	disable iff (!arst_n) (cond) |=> (prop)) else $error("tesm: next-cycle check failed");
`else
`define TESM_ASSERT(lbl, prop)
`define TESM_ASSERT_IMPL(lbl, cond, prop)
`define TESM_ASSERT_NEXT(lbl, cond, prop)
`endif
`endif

// ===== src/tesm_pkg.sv =====
// ----------------------------------------------------------------------------
// tesm_pkg
// Types and constants shared by the subscription matcher modules.
// ----------------------------------------------------------------------------
package tesm_pkg;

	localparam int MaxResults = 16;
	localparam int ResW = $clog2(MaxResults + 1);

	localparam logic [1:0] OP_REGISTER = 2'd0;
	localparam logic [1:0] OP_CANCEL   = 2'd1;
	localparam logic [1:0] OP_FRAME    = 2'd2;

	localparam logic [1:0] RK_MATCH = 2'd0;
	localparam logic [1:0] RK_ADDED = 2'd1;
	localparam logic [1:0] RK_FULL  = 2'd2;

	localparam logic CFG_WATCHED_CATEGORY = 1'b0;
	localparam logic CFG_SUBCATEGORY_BASE = 1'b1;

	typedef enum logic [1:0] {
		CMD_REG    = 2'd0,
		CMD_CANCEL = 2'd1,
		CMD_FRAME  = 2'd2
	} cmd_kind_t;

	// One classified word handed from the front to the back.
	typedef struct packed {
		cmd_kind_t        kind;
		logic [7:0]       sub;
		logic [1:0]       cnt;
		logic [2:0][31:0] key;
		logic [7:0]       obs;
		logic             shot;
		logic [31:0]      tick;
	} cmd_t;

	// Table entry descriptor, without the key words.
	typedef struct packed {
		logic [1:0] cnt;
		logic       shot;
		logic [7:0] obs;
		logic [7:0] sub;
	} tag_t;

endpackage

// ===== src/tesm_front.sv =====
// ----------------------------------------------------------------------------
// tesm_front
// Holds the filter registers, accepts words and classifies them.
// ----------------------------------------------------------------------------
module tesm_front #(
	parameter int MAX_WORDS = 3
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_write_en,
	input  logic [0:0]        cfg_index,
	input  logic [7:0]        cfg_data,
	input  logic              item_valid,
	output logic              item_ready,
	input  logic [1:0]        opcode,
	input  logic [7:0]        category,
	input  logic [7:0]        sub_category,
	input  logic [3:0]        word_count,
	input  logic [31:0]       key_word0,
	input  logic [31:0]       key_word1,
	input  logic [31:0]       key_word2,
	input  logic [7:0]        observer_id,
	input  logic              one_shot,
	input  logic [31:0]       tick_count,
	output logic              push_valid,
	input  logic              push_ready,
	output tesm_pkg::cmd_t    push_cmd
);

	logic [7:0] watched_category_q;
	logic [7:0] subcategory_base_q;
	logic       keep;
	logic       small_key;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			watched_category_q <= '0;
			subcategory_base_q <= '0;
		end else if (cfg_write_en) begin
			if (cfg_index[0] == tesm_pkg::CFG_WATCHED_CATEGORY) begin
				watched_category_q <= cfg_data;
			end else begin
				subcategory_base_q <= cfg_data;
			end
		end
	end

	assign small_key = (word_count <= 4'(MAX_WORDS));

	// Filtered frames, oversized frames and the unused opcode are taken and dropped here.
	always_comb begin
		keep = 1'b0;
		push_cmd.kind = tesm_pkg::CMD_REG;
		case (opcode)
			tesm_pkg::OP_REGISTER: begin
				keep = 1'b1;
				push_cmd.kind = tesm_pkg::CMD_REG;
			end
			tesm_pkg::OP_CANCEL: begin
				keep = 1'b1;
				push_cmd.kind = tesm_pkg::CMD_CANCEL;
			end
			tesm_pkg::OP_FRAME: begin
				keep = (category == watched_category_q) &&
					(sub_category > subcategory_base_q) && small_key;
				push_cmd.kind = tesm_pkg::CMD_FRAME;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
		push_cmd.sub  = sub_category;
		push_cmd.cnt  = small_key ? word_count[1:0] : 2'(MAX_WORDS);
		push_cmd.key  = {key_word2, key_word1, key_word0};
		push_cmd.obs  = observer_id;
		push_cmd.shot = one_shot;
		push_cmd.tick = tick_count;
	end

	assign item_ready = push_ready;
	assign push_valid = item_valid && keep;

endmodule

// ===== src/tesm_queue.sv =====
// ----------------------------------------------------------------------------
// tesm_queue
// Two-entry queue that decouples the front from the table engine.
// ----------------------------------------------------------------------------
module tesm_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  tesm_pkg::cmd_t push_cmd,
	output logic           pop_valid,
	input  logic           pop_ready,
	output tesm_pkg::cmd_t pop_cmd
);

	tesm_pkg::cmd_t slot_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     fill_q;
	logic           do_push;
	logic           do_pop;

	assign push_ready = (fill_q != 2'd2);
	assign pop_valid  = (fill_q != 2'd0);
	assign pop_cmd    = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

endmodule

// ===== src/tesm_back.sv =====
// ----------------------------------------------------------------------------
// tesm_back
// Subscription table engine: append, match scan, compaction and results.
// ----------------------------------------------------------------------------
`include "trace_event_subscription_matcher_defines.svh"

module tesm_back #(
	parameter int TABLE_DEPTH = 16,
	parameter int MAX_WORDS   = 3
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_ready,
	input  tesm_pkg::cmd_t cmd,
	output logic           result_valid,
	input  logic           result_ready,
	output logic [1:0]     result_kind,
	output logic [7:0]     matched_observer,
	output logic [31:0]    event_tick,
	output logic           last_result
);

	localparam int IDX_W     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W     = $clog2(TABLE_DEPTH + 1);
	localparam int WORD_BITS = MAX_WORDS * 32;

	typedef enum logic [4:0] {
		ST_IDLE    = 5'b00001,
		ST_REG     = 5'b00010,
		ST_MATCH   = 5'b00100,
		ST_FLUSH   = 5'b01000,
		ST_COMPACT = 5'b10000
	} state_t;

	tesm_pkg::tag_t         tag_mem  [TABLE_DEPTH];
	logic [WORD_BITS-1:0]   word_mem [TABLE_DEPTH];
	tesm_pkg::tag_t         tag_rd_s1;
	logic [WORD_BITS-1:0]   word_rd_s1;

	state_t                 state_q;
	tesm_pkg::cmd_t         cmd_q;
	logic [CNT_W-1:0]       count_q;
	logic [CNT_W-1:0]       ptr_q;
	logic [CNT_W-1:0]       wr_q;
	logic                   valid_s1;
	logic [IDX_W-1:0]       idx_s1;
	logic [TABLE_DEPTH-1:0] kill_q;
	logic [tesm_pkg::ResW-1:0] nres_q;
	logic                   held_valid_q;
	logic [7:0]             held_obs_q;

	logic                   slot_free;
	logic                   full;
	logic                   words_eq;
	logic                   entry_hit;
	logic                   hit_s1;
	logic                   want_emit;
	logic                   stall;
	logic                   match_issue;
	logic                   compact_issue;
	logic [IDX_W-1:0]       match_idx;
	logic [IDX_W-1:0]       raddr;
	logic                   we;
	logic [IDX_W-1:0]       waddr;
	tesm_pkg::tag_t         wtag;
	logic [WORD_BITS-1:0]   wwords;
	logic                   push;
	logic [1:0]             push_kind;
	logic [7:0]             push_obs;
	logic [31:0]            push_tick;
	logic                   push_last;

	assign slot_free = !result_valid || result_ready;
	assign full      = (count_q == CNT_W'(TABLE_DEPTH));
	assign cmd_ready = (state_q == ST_IDLE);

	always_comb begin
		words_eq = 1'b1;
		for (int w = 0; w < MAX_WORDS; w++) begin
			if ((w < int'(cmd_q.cnt)) && (word_rd_s1[w*32 +: 32] != cmd_q.key[w])) begin
				words_eq = 1'b0;
			end
		end
	end

	assign entry_hit = (cmd_q.kind == tesm_pkg::CMD_CANCEL) ?
		(tag_rd_s1.obs == cmd_q.obs) :
		((tag_rd_s1.sub == cmd_q.sub) && (tag_rd_s1.cnt == cmd_q.cnt) && words_eq);
	assign hit_s1    = (state_q == ST_MATCH) && valid_s1 && entry_hit;
	assign want_emit = hit_s1 && (cmd_q.kind == tesm_pkg::CMD_FRAME) &&
		(nres_q < tesm_pkg::ResW'(tesm_pkg::MaxResults));
	assign stall     = want_emit && held_valid_q && !slot_free;

	assign match_issue   = (state_q == ST_MATCH) && !stall && (ptr_q != '0);
	assign match_idx     = IDX_W'(ptr_q - CNT_W'(1));
	assign compact_issue = (state_q == ST_COMPACT) && (ptr_q != count_q);

	always_comb begin
		case (state_q)
			ST_MATCH:   raddr = stall ? idx_s1 : match_idx;
			ST_COMPACT: raddr = IDX_W'(ptr_q);
			default:    raddr = '0;
		endcase
	end

	always_comb begin
		we     = 1'b0;
		waddr  = IDX_W'(count_q);
		wtag   = tag_rd_s1;
		wwords = word_rd_s1;
		if (state_q == ST_REG) begin
			we       = slot_free && !full;
			wtag.sub  = cmd_q.sub;
			wtag.obs  = cmd_q.obs;
			wtag.shot = cmd_q.shot;
			wtag.cnt  = cmd_q.cnt;
			for (int w = 0; w < MAX_WORDS; w++) begin
				wwords[w*32 +: 32] = cmd_q.key[w];
			end
		end else if (state_q == ST_COMPACT) begin
			we    = valid_s1 && !kill_q[idx_s1];
			waddr = IDX_W'(wr_q);
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			tag_mem[waddr]  <= wtag;
			word_mem[waddr] <= wwords;
		end
		tag_rd_s1  <= tag_mem[raddr];
		word_rd_s1 <= word_mem[raddr];
	end

	always_comb begin
		push      = 1'b0;
		push_kind = tesm_pkg::RK_MATCH;
		push_obs  = held_obs_q;
		push_tick = cmd_q.tick;
		push_last = 1'b0;
		case (state_q)
			ST_REG: begin
				push      = slot_free;
				push_kind = full ? tesm_pkg::RK_FULL : tesm_pkg::RK_ADDED;
				push_obs  = cmd_q.obs;
				push_tick = '0;
				push_last = 1'b1;
			end
			ST_MATCH: begin
				push = want_emit && held_valid_q && !stall;
			end
			ST_FLUSH: begin
				push      = held_valid_q && slot_free;
				push_last = 1'b1;
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (push) begin
			result_kind      <= push_kind;
			matched_observer <= push_obs;
			event_tick       <= push_tick;
			last_result      <= push_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cmd_q        <= '0;
			count_q      <= '0;
			ptr_q        <= '0;
			wr_q         <= '0;
			valid_s1     <= 1'b0;
			idx_s1       <= '0;
			kill_q       <= '0;
			nres_q       <= '0;
			held_valid_q <= 1'b0;
			held_obs_q   <= '0;
			result_valid <= 1'b0;
		end else begin
			if (push) begin
				result_valid <= 1'b1;
			end else if (result_ready) begin
				result_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						cmd_q    <= cmd;
						ptr_q    <= count_q;
						kill_q   <= '0;
						nres_q   <= '0;
						valid_s1 <= 1'b0;
						state_q  <= (cmd.kind == tesm_pkg::CMD_REG) ? ST_REG : ST_MATCH;
					end
				end
				ST_REG: begin
					if (slot_free) begin
						if (!full) begin
							count_q <= count_q + CNT_W'(1);
						end
						state_q <= ST_IDLE;
					end
				end
				ST_MATCH: begin
					if (!stall) begin
						valid_s1 <= match_issue;
						if (match_issue) begin
							idx_s1 <= match_idx;
							ptr_q  <= ptr_q - CNT_W'(1);
						end
						if (hit_s1 && ((cmd_q.kind == tesm_pkg::CMD_CANCEL) || tag_rd_s1.shot)) begin
							kill_q[idx_s1] <= 1'b1;
						end
						if (want_emit) begin
							held_valid_q <= 1'b1;
							held_obs_q   <= tag_rd_s1.obs;
							nres_q       <= nres_q + tesm_pkg::ResW'(1);
						end
						if ((ptr_q == '0) && !valid_s1) begin
							state_q <= ST_FLUSH;
						end
					end
				end
				ST_FLUSH: begin
					if (!held_valid_q || slot_free) begin
						held_valid_q <= 1'b0;
						ptr_q        <= '0;
						wr_q         <= '0;
						valid_s1     <= 1'b0;
						state_q      <= ST_COMPACT;
					end
				end
				ST_COMPACT: begin
					valid_s1 <= compact_issue;
					if (compact_issue) begin
						idx_s1 <= IDX_W'(ptr_q);
						ptr_q  <= ptr_q + CNT_W'(1);
					end
					if (valid_s1 && !kill_q[idx_s1]) begin
						wr_q <= wr_q + CNT_W'(1);
					end
					if (!compact_issue && !valid_s1) begin
						count_q <= wr_q;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`TESM_ASSERT(a_count_in_range, count_q <= CNT_W'(TABLE_DEPTH))
	`TESM_ASSERT_IMPL(a_held_only_in_scan, held_valid_q, (state_q == ST_MATCH) || (state_q == ST_FLUSH))
	`TESM_ASSERT_IMPL(a_compact_behind_read, state_q == ST_COMPACT, wr_q <= ptr_q)
	`TESM_ASSERT_NEXT(a_stall_keeps_entry, stall, valid_s1 && $stable(idx_s1))
	`TESM_ASSERT(a_result_cap, nres_q <= tesm_pkg::ResW'(tesm_pkg::MaxResults))

endmodule

// ===== src/trace_event_subscription_matcher.sv =====
// ----------------------------------------------------------------------------
// trace_event_subscription_matcher
// Ordered subscription table that matches trace frames against keys.
// ----------------------------------------------------------------------------
//
//   channel   handshake                   direction  payload
//   config    cfg_write_en                in         cfg_index, cfg_data
//   item      item_valid / item_ready     in         opcode ... tick_count
//   result    result_valid / result_ready out        result_kind ... last_result
//
// A register word goes from the engine's command register into the result register once the result slot is free.
// A cancel or frame word scans the table newest to oldest at one entry per
// cycle through the registered table read port while no result is stalled,
// then compacts it oldest to newest at one entry per cycle.
// Reset clears the table fill count and the filter registers; the table
// contents need no clearing since only filled entries are read.
// A stalled result holds the engine wherever it has a result word to hand
// over (register result, match scan, final flush); the front keeps taking
// words into its two-entry queue while the queue has room.
//
// The front holds the watched category and subcategory base registers and
// drops words that can never produce a result (filtered or oversized
// frames and the unused opcode) right at the port. Everything else goes
// through a short queue to the table engine. The engine keeps one match
// back in a holding register so that it can mark the final result of a
// frame once the scan ends; matches past the sixteenth are not reported
// but still remove their one-shot entries.
// ----------------------------------------------------------------------------
module trace_event_subscription_matcher #(
	parameter int TABLE_DEPTH = 16,
	parameter int MAX_WORDS   = 3
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write_en,
	input  logic [0:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic [1:0]  opcode,
	input  logic [7:0]  category,
	input  logic [7:0]  sub_category,
	input  logic [3:0]  word_count,
	input  logic [31:0] key_word0,
	input  logic [31:0] key_word1,
	input  logic [31:0] key_word2,
	input  logic [7:0]  observer_id,
	input  logic        one_shot,
	input  logic [31:0] tick_count,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [1:0]  result_kind,
	output logic [7:0]  matched_observer,
	output logic [31:0] event_tick,
	output logic        last_result
);

	logic           push_valid;
	logic           push_ready;
	tesm_pkg::cmd_t push_cmd;
	logic           pop_valid;
	logic           pop_ready;
	tesm_pkg::cmd_t pop_cmd;

	tesm_front #(
		.MAX_WORDS(MAX_WORDS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.opcode       (opcode),
		.category     (category),
		.sub_category (sub_category),
		.word_count   (word_count),
		.key_word0    (key_word0),
		.key_word1    (key_word1),
		.key_word2    (key_word2),
		.observer_id  (observer_id),
		.one_shot     (one_shot),
		.tick_count   (tick_count),
		.push_valid   (push_valid),
		.push_ready   (push_ready),
		.push_cmd     (push_cmd)
	);

	tesm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_cmd    (pop_cmd)
	);

	tesm_back #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.MAX_WORDS  (MAX_WORDS)
	) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd_valid        (pop_valid),
		.cmd_ready        (pop_ready),
		.cmd              (pop_cmd),
		.result_valid     (result_valid),
		.result_ready     (result_ready),
		.result_kind      (result_kind),
		.matched_observer (matched_observer),
		.event_tick       (event_tick),
		.last_result      (last_result)
	);

endmodule
